[design/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define RSG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Check a property on every edge, reset included.
`define RSG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

[design/rsg_pkg.sv]
package rsg_pkg;

    localparam logic [18:0] TWO_PI_Q16         = 19'd411775;
    localparam logic [32:0] HALF_PI_Q30        = 33'd1686629713;
    localparam logic [32:0] PI_Q30             = 33'd3373259426;
    localparam logic [32:0] THREE_HALF_PI_Q30  = 33'd5059889139;
    localparam logic [32:0] QUARTER_PI_Q30     = 33'd843314857;
    localparam logic [30:0] ONE_Q30            = 31'h4000_0000;

    localparam logic [2:0] CFG_START_ANGLE     = 3'd0;
    localparam logic [2:0] CFG_ANGLE_STEP      = 3'd1;
    localparam logic [2:0] CFG_GAP_THRESHOLD   = 3'd2;
    localparam logic [2:0] CFG_MIN_POINTS      = 3'd3;
    localparam logic [2:0] CFG_MAX_CENTER_DIST = 3'd4;

    typedef struct packed {
        logic signed [18:0] start_angle;
        logic [16:0]        angle_step;
        logic [15:0]        gap_threshold;
        logic [12:0]        min_points;
        logic [15:0]        max_center_distance;
    } t_cfg;

    typedef struct packed {
        logic first;
        logic last;
    } t_flags;

endpackage

[design/rsg_div.sv]
module rsg_div #(
    parameter int DW = 29,
    parameter int NW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_div;
    logic [NW:0]   w_sh;
    logic          w_ge;

    assign w_sh   = {r_rem, r_quo[DW-1]};
    assign w_ge   = w_sh >= {1'b0, r_div};
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? NW'(w_sh - {1'b0, r_div}) : w_sh[NW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

endmodule

[design/rsg_front.sv]
module rsg_front #(
    parameter int MAX_POINTS = 4096,
    localparam int IW = $clog2(MAX_POINTS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsg_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [15:0]     i_range_mm,
    input  logic            i_last_in_scan,
    input  logic            i_full,
    output logic            o_push,
    output logic [15:0]     o_range,
    output logic [18:0]     o_angle,
    output logic [IW-1:0]   o_index,
    output rsg_pkg::t_flags o_flags
);
    import rsg_pkg::*;

    logic [IW-1:0]      r_idx;
    logic [18:0]        r_cur_angle;
    logic signed [19:0] w_sa;
    logic [19:0]        w_sum;
    logic [18:0]        w_first_angle;
    logic [18:0]        w_next_angle;
    logic               w_end;

    always_comb begin
        w_sa = {i_cfg.start_angle[18], i_cfg.start_angle};
        if (w_sa < 0) begin
            w_sa = w_sa + 20'sd411775;
        end
        w_first_angle = w_sa[18:0];
        w_sum = {1'b0, r_cur_angle} + {3'b0, i_cfg.angle_step};
        w_next_angle = (w_sum >= {1'b0, TWO_PI_Q16}) ? 19'(w_sum - {1'b0, TWO_PI_Q16})
                                                     : w_sum[18:0];
    end

    assign w_end         = i_last_in_scan || (r_idx >= IW'(MAX_POINTS - 1));
    assign o_ready       = !i_full;
    assign o_push        = i_valid && !i_full;
    assign o_range       = i_range_mm;
    assign o_angle       = (r_idx == '0) ? w_first_angle : w_next_angle;
    assign o_index       = r_idx;
    assign o_flags.first = (r_idx == '0);
    assign o_flags.last  = w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cur_angle <= '0;
        end else if (o_push) begin
            r_cur_angle <= o_angle;
            r_idx       <= w_end ? '0 : r_idx + 1'b1;
        end
    end

endmodule

[design/rsg_queue.sv]
module rsg_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[design/rsg_back.sv]
module rsg_back #(
    parameter int MAX_POINTS = 4096,
    parameter int TRIG_BITS  = 16,
    localparam int IW = $clog2(MAX_POINTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsg_pkg::t_cfg      i_cfg,
    input  logic               i_item_valid,
    output logic               o_pop,
    input  logic [15:0]        i_range,
    input  logic [18:0]        i_angle,
    input  logic [IW-1:0]      i_index,
    input  rsg_pkg::t_flags    i_flags,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [16:0] o_center_x,
    output logic signed [16:0] o_center_y,
    output logic [11:0]        o_first_index,
    output logic [11:0]        o_final_index
);
    import rsg_pkg::*;

    localparam int PW  = IW + 1;
    localparam int T   = TRIG_BITS;
    localparam int TW  = T + 2;
    localparam int PMW = T + 17;
    localparam int GW  = T + 35;
    localparam int DW  = 29;
    localparam logic [31:0] RND = 32'(1) << (29 - T);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_TSET = 5'd1;
    localparam logic [4:0] S_TSQ  = 5'd2;
    localparam logic [4:0] S_TMUL = 5'd3;
    localparam logic [4:0] S_TRCP = 5'd4;
    localparam logic [4:0] S_TQD  = 5'd5;
    localparam logic [4:0] S_TFIX = 5'd6;
    localparam logic [4:0] S_TSIN = 5'd7;
    localparam logic [4:0] S_TEND = 5'd8;
    localparam logic [4:0] S_PX   = 5'd9;
    localparam logic [4:0] S_PY   = 5'd10;
    localparam logic [4:0] S_DISP = 5'd11;
    localparam logic [4:0] S_GAA  = 5'd12;
    localparam logic [4:0] S_GBB  = 5'd13;
    localparam logic [4:0] S_GAB  = 5'd14;
    localparam logic [4:0] S_GG   = 5'd15;
    localparam logic [4:0] S_GP   = 5'd16;
    localparam logic [4:0] S_GCMP = 5'd17;
    localparam logic [4:0] S_CLS  = 5'd18;
    localparam logic [4:0] S_CXW  = 5'd19;
    localparam logic [4:0] S_CYS  = 5'd20;
    localparam logic [4:0] S_CYW  = 5'd21;
    localparam logic [4:0] S_DX   = 5'd22;
    localparam logic [4:0] S_DY   = 5'd23;
    localparam logic [4:0] S_DCMP = 5'd24;
    localparam logic [4:0] S_EMIT = 5'd25;
    localparam logic [4:0] S_FIN  = 5'd26;

    function automatic logic [6:0] trig_div(input logic [3:0] k);
        logic [6:0] d;
        case (k)
            4'd0:    d = 7'd72;
            4'd1:    d = 7'd42;
            4'd2:    d = 7'd20;
            4'd3:    d = 7'd6;
            4'd4:    d = 7'd90;
            4'd5:    d = 7'd56;
            4'd6:    d = 7'd30;
            4'd7:    d = 7'd12;
            default: d = 7'd2;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] trig_rcp(input logic [3:0] k);
        logic [31:0] m;
        case (k)
            4'd0:    m = 32'd59652323;
            4'd1:    m = 32'd102261126;
            4'd2:    m = 32'd214748364;
            4'd3:    m = 32'd715827882;
            4'd4:    m = 32'd47721858;
            4'd5:    m = 32'd76695844;
            4'd6:    m = 32'd143165576;
            4'd7:    m = 32'd357913941;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

    function automatic logic signed [28:0] sat_sum(input logic signed [29:0] v);
        logic signed [28:0] res;
        if (v > 30'sd268435455) begin
            res = 29'sd268435455;
        end else if (v < -30'sd268435455) begin
            res = -29'sd268435455;
        end else begin
            res = v[28:0];
        end
        return res;
    endfunction

    function automatic logic signed [16:0] proj(input logic [15:0] rg,
                                                input logic signed [TW-1:0] tr);
        logic [TW-1:0]  mag_t;
        logic [PMW-1:0] acc;
        logic [16:0]    v;
        mag_t = tr[TW-1] ? TW'(-tr) : TW'(tr);
        acc   = PMW'(rg * mag_t[T:0]) + (PMW'(1) << (T - 1));
        v     = acc[T+16:T];
        return tr[TW-1] ? -$signed(v) : $signed(v);
    endfunction

    function automatic logic signed [16:0] centro(input logic [DW-1:0] q, input logic neg);
        logic [16:0] m;
        m = (q > DW'(65535)) ? 17'd65535 : q[16:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    logic [4:0]          r_state;
    logic [15:0]         r_range;
    logic [18:0]         r_ang;
    logic [IW-1:0]       r_idx;
    logic                r_first;
    logic                r_end;
    logic                r_tsel;
    logic                r_do_open;
    logic [IW-1:0]       r_fidx;

    logic [15:0]         r_prev_range;
    logic [IW-1:0]       r_seg_start;
    logic [PW-1:0]       r_seg_points;
    logic signed [28:0]  r_sum_x;
    logic signed [28:0]  r_sum_y;

    logic [1:0]          r_quad;
    logic                r_fold;
    logic [29:0]         r_x;
    logic [29:0]         r_x2;
    logic [30:0]         r_t;
    logic [30:0]         r_s;
    logic [3:0]          r_k;
    logic [30:0]         r_prod;
    logic [30:0]         r_q0;
    logic [31:0]         r_qd;
    logic signed [TW-1:0] r_co;
    logic signed [TW-1:0] r_si;
    logic signed [TW-1:0] r_sc;
    logic signed [16:0]  r_px;
    logic signed [16:0]  r_py;

    logic [32:0]         r_gs;
    logic [31:0]         r_ab;
    logic [31:0]         r_gg;
    logic [T+33:0]       r_gp;
    logic signed [16:0]  r_cx;
    logic signed [16:0]  r_cy;
    logic [33:0]         r_dd;

    logic                r_ov;
    logic signed [16:0]  r_out_x;
    logic signed [16:0]  r_out_y;
    logic [11:0]         r_out_first;
    logic [11:0]         r_out_final;

    logic [18:0]         w_tang;
    logic [32:0]         w_r;
    logic [32:0]         w_rr;
    logic [1:0]          w_quad;
    logic                w_fold;
    logic [29:0]         w_x;
    logic [59:0]         w_mxx;
    logic [60:0]         w_mxt;
    logic [60:0]         w_mxs;
    logic [62:0]         w_mrc;
    logic [31:0]         w_diff;
    logic [30:0]         w_q;
    logic [31:0]         w_rc;
    logic [31:0]         w_rs;
    logic signed [TW-1:0] w_c0;
    logic signed [TW-1:0] w_s0;
    logic signed [TW-1:0] w_co;
    logic signed [TW-1:0] w_si;
    logic [TW-1:0]       w_asc;
    logic signed [GW-1:0] w_base;
    logic signed [GW-1:0] w_cross;
    logic signed [GW-1:0] w_d2;
    logic signed [GW-1:0] w_g2;
    logic [DW-1:0]       w_magx;
    logic [DW-1:0]       w_magy;
    logic                w_cls_pass;
    logic                w_div_start;
    logic [DW-1:0]       w_div_num;
    logic                w_div_done;
    logic [DW-1:0]       w_div_quot;
    logic                w_emit_ok;

    always_comb begin
        w_tang = r_tsel ? {2'b0, i_cfg.angle_step} : r_ang;
        w_r    = {w_tang, 14'b0};
        if (w_r >= THREE_HALF_PI_Q30) begin
            w_quad = 2'd3;
            w_rr   = w_r - THREE_HALF_PI_Q30;
        end else if (w_r >= PI_Q30) begin
            w_quad = 2'd2;
            w_rr   = w_r - PI_Q30;
        end else if (w_r >= HALF_PI_Q30) begin
            w_quad = 2'd1;
            w_rr   = w_r - HALF_PI_Q30;
        end else begin
            w_quad = 2'd0;
            w_rr   = w_r;
        end
        w_fold = w_rr > QUARTER_PI_Q30;
        if (w_fold) begin
            w_x = (w_rr < HALF_PI_Q30) ? 30'(HALF_PI_Q30 - w_rr) : 30'd0;
        end else begin
            w_x = w_rr[29:0];
        end

        w_mxx  = r_x * r_x;
        w_mxt  = r_x2 * r_t;
        w_mxs  = r_x * r_t;
        w_mrc  = r_prod * trig_rcp(r_k);
        w_diff = {1'b0, r_prod} - r_qd;
        w_q    = (w_diff >= 32'(trig_div(r_k))) ? r_q0 + 1'b1 : r_q0;

        w_rc = {1'b0, (r_fold ? r_s : r_t)} + RND;
        w_rs = {1'b0, (r_fold ? r_t : r_s)} + RND;
        w_c0 = $signed(w_rc[31 -: TW]);
        w_s0 = $signed(w_rs[31 -: TW]);
        case (r_quad)
            2'd0: begin
                w_co = w_c0;
                w_si = w_s0;
            end
            2'd1: begin
                w_co = -w_s0;
                w_si = w_c0;
            end
            2'd2: begin
                w_co = -w_c0;
                w_si = -w_s0;
            end
            default: begin
                w_co = w_s0;
                w_si = -w_c0;
            end
        endcase

        w_asc   = r_sc[TW-1] ? TW'(-r_sc) : TW'(r_sc);
        w_base  = $signed(GW'({r_gs, {T{1'b0}}}));
        w_cross = $signed(GW'(r_gp));
        w_d2    = r_sc[TW-1] ? w_base + w_cross : w_base - w_cross;
        w_g2    = $signed(GW'({r_gg, {T{1'b0}}}));

        w_magx = r_sum_x[28] ? DW'(-r_sum_x) : DW'(r_sum_x);
        w_magy = r_sum_y[28] ? DW'(-r_sum_y) : DW'(r_sum_y);
        w_cls_pass = (r_seg_points != '0) &&
                     (32'(r_seg_points) >= 32'(i_cfg.min_points));
        w_div_start = ((r_state == S_CLS) && w_cls_pass) || (r_state == S_CYS);
        w_div_num   = ((r_state == S_CYS) ? w_magy : w_magx) + DW'(r_seg_points >> 1);
        w_emit_ok   = !r_ov || i_ready;
    end

    rsg_div #(
        .DW (DW),
        .NW (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (r_seg_points),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign o_pop         = (r_state == S_IDLE) && i_item_valid;
    assign o_valid       = r_ov;
    assign o_center_x    = r_out_x;
    assign o_center_y    = r_out_y;
    assign o_first_index = r_out_first;
    assign o_final_index = r_out_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ov         <= 1'b0;
            r_prev_range <= '0;
            r_seg_start  <= '0;
            r_seg_points <= '0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_tsel       <= 1'b0;
            r_do_open    <= 1'b0;
        end else begin
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_range <= i_range;
                        r_ang   <= i_angle;
                        r_idx   <= i_index;
                        r_first <= i_flags.first;
                        r_end   <= i_flags.last;
                        r_tsel  <= 1'b0;
                        r_state <= S_TSET;
                    end
                end
                S_TSET: begin
                    r_quad  <= w_quad;
                    r_fold  <= w_fold;
                    r_x     <= w_x;
                    r_state <= S_TSQ;
                end
                S_TSQ: begin
                    r_x2    <= w_mxx[59:30];
                    r_t     <= ONE_Q30;
                    r_k     <= 4'd0;
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_prod  <= w_mxt[60:30];
                    r_state <= S_TRCP;
                end
                S_TRCP: begin
                    r_q0    <= w_mrc[62:32];
                    r_state <= S_TQD;
                end
                S_TQD: begin
                    r_qd    <= 32'(r_q0 * trig_div(r_k));
                    r_state <= S_TFIX;
                end
                S_TFIX: begin
                    r_t <= ONE_Q30 - w_q;
                    if (r_k == 4'd3) begin
                        r_state <= S_TSIN;
                    end else if (r_k == 4'd8) begin
                        r_state <= S_TEND;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_TMUL;
                    end
                end
                S_TSIN: begin
                    r_s     <= w_mxs[60:30];
                    r_t     <= ONE_Q30;
                    r_k     <= 4'd4;
                    r_state <= S_TMUL;
                end
                S_TEND: begin
                    if (r_tsel) begin
                        r_sc    <= w_co;
                        r_state <= S_GAA;
                    end else begin
                        r_co    <= w_co;
                        r_si    <= w_si;
                        r_state <= S_PX;
                    end
                end
                S_PX: begin
                    r_px    <= proj(r_range, r_co);
                    r_state <= S_PY;
                end
                S_PY: begin
                    r_py    <= proj(r_range, r_si);
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    if (r_first) begin
                        r_do_open <= 1'b1;
                        r_state   <= S_FIN;
                    end else if (r_end) begin
                        r_sum_x      <= sat_sum(30'(r_sum_x) + 30'(r_px));
                        r_sum_y      <= sat_sum(30'(r_sum_y) + 30'(r_py));
                        r_seg_points <= r_seg_points + 1'b1;
                        r_fidx       <= r_idx;
                        r_do_open    <= 1'b0;
                        r_state      <= S_CLS;
                    end else begin
                        r_tsel  <= 1'b1;
                        r_state <= S_TSET;
                    end
                end
                S_GAA: begin
                    r_gs    <= 33'(r_prev_range * r_prev_range);
                    r_state <= S_GBB;
                end
                S_GBB: begin
                    r_gs    <= r_gs + 33'(r_range * r_range);
                    r_state <= S_GAB;
                end
                S_GAB: begin
                    r_ab    <= r_prev_range * r_range;
                    r_state <= S_GG;
                end
                S_GG: begin
                    r_gg    <= i_cfg.gap_threshold * i_cfg.gap_threshold;
                    r_state <= S_GP;
                end
                S_GP: begin
                    r_gp    <= {r_ab, 1'b0} * w_asc[T:0];
                    r_state <= S_GCMP;
                end
                S_GCMP: begin
                    if (w_d2 > w_g2) begin
                        r_fidx    <= r_idx - 1'b1;
                        r_do_open <= 1'b1;
                        r_state   <= S_CLS;
                    end else begin
                        r_sum_x      <= sat_sum(30'(r_sum_x) + 30'(r_px));
                        r_sum_y      <= sat_sum(30'(r_sum_y) + 30'(r_py));
                        r_seg_points <= r_seg_points + 1'b1;
                        r_do_open    <= 1'b0;
                        r_state      <= S_FIN;
                    end
                end
                S_CLS: begin
                    r_state <= w_cls_pass ? S_CXW : S_FIN;
                end
                S_CXW: begin
                    if (w_div_done) begin
                        r_cx    <= centro(w_div_quot, r_sum_x[28]);
                        r_state <= S_CYS;
                    end
                end
                S_CYS: begin
                    r_state <= S_CYW;
                end
                S_CYW: begin
                    if (w_div_done) begin
                        r_cy    <= centro(w_div_quot, r_sum_y[28]);
                        r_state <= S_DX;
                    end
                end
                S_DX: begin
                    r_dd    <= $unsigned(34'(r_cx * r_cx));
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_dd    <= r_dd + $unsigned(34'(r_cy * r_cy));
                    r_state <= S_DCMP;
                end
                S_DCMP: begin
                    if (r_dd < 34'(i_cfg.max_center_distance * i_cfg.max_center_distance)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_EMIT: begin
                    if (w_emit_ok) begin
                        r_ov    <= 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_prev_range <= r_range;
                    if (r_end) begin
                        r_seg_start  <= '0;
                        r_seg_points <= '0;
                        r_sum_x      <= '0;
                        r_sum_y      <= '0;
                    end else if (r_do_open) begin
                        r_seg_start  <= r_idx;
                        r_seg_points <= PW'(1);
                        r_sum_x      <= 29'(r_px);
                        r_sum_y      <= 29'(r_py);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_emit_ok) begin
            r_out_x     <= r_cx;
            r_out_y     <= r_cy;
            r_out_first <= 12'(r_seg_start);
            r_out_final <= 12'(r_fidx);
        end
    end

endmodule

[design/range_scan_gap_segmenter_unit.sv]
// The back end takes one sample at a time from a two-entry queue and finishes it before it pops
// the next; an interior sample also runs a gap test, and a closed segment a centroid division.
// Sine and cosine come from a Taylor series on several multipliers, and the centroid from a
// serial restoring divider.
// Reset (synchronous, active low) restores register defaults and starts a fresh scan.
module range_scan_gap_segmenter_unit #(
    parameter int MAX_POINTS = 4096,
    parameter int TRIG_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_addr,
    input  logic [18:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_range_mm,
    input  logic               i_last_in_scan,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [16:0] o_center_x,
    output logic signed [16:0] o_center_y,
    output logic [11:0]        o_first_index,
    output logic [11:0]        o_final_index
);
    import rsg_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int QW = 16 + 19 + IW + 2;

    t_cfg          r_cfg;
    logic          f_push;
    logic          q_full;
    logic [15:0]   f_range;
    logic [18:0]   f_angle;
    logic [IW-1:0] f_index;
    t_flags        f_flags;
    logic          q_valid;
    logic          b_pop;
    logic [QW-1:0] q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_angle         <= '0;
            r_cfg.angle_step          <= 17'd1144;
            r_cfg.gap_threshold       <= 16'd100;
            r_cfg.min_points          <= 13'd3;
            r_cfg.max_center_distance <= 16'd5000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_START_ANGLE:     r_cfg.start_angle         <= i_cfg_wdata;
                CFG_ANGLE_STEP:      r_cfg.angle_step          <= i_cfg_wdata[16:0];
                CFG_GAP_THRESHOLD:   r_cfg.gap_threshold       <= i_cfg_wdata[15:0];
                CFG_MIN_POINTS:      r_cfg.min_points          <= i_cfg_wdata[12:0];
                CFG_MAX_CENTER_DIST: r_cfg.max_center_distance <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    rsg_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_range_mm     (i_range_mm),
        .i_last_in_scan (i_last_in_scan),
        .i_full         (q_full),
        .o_push         (f_push),
        .o_range        (f_range),
        .o_angle        (f_angle),
        .o_index        (f_index),
        .o_flags        (f_flags)
    );

    rsg_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_range, f_angle, f_index, f_flags}),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    rsg_back #(
        .MAX_POINTS (MAX_POINTS),
        .TRIG_BITS  (TRIG_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item_valid  (q_valid),
        .o_pop         (b_pop),
        .i_range       (q_data[QW-1 -: 16]),
        .i_angle       (q_data[QW-17 -: 19]),
        .i_index       (q_data[IW+1:2]),
        .i_flags       (t_flags'(q_data[1:0])),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_center_x    (o_center_x),
        .o_center_y    (o_center_y),
        .o_first_index (o_first_index),
        .o_final_index (o_final_index)
    );

endmodule

[design/rsg_checker.sv]
`include "assert_macros.svh"

module rsg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_wr_en,
    input logic [2:0]         i_cfg_addr,
    input logic [18:0]        i_cfg_wdata,
    input logic               i_valid,
    input logic               o_ready,
    input logic [15:0]        i_range_mm,
    input logic               i_last_in_scan,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [16:0] o_center_x,
    input logic signed [16:0] o_center_y,
    input logic [11:0]        o_first_index,
    input logic [11:0]        o_final_index
);

    `RSG_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    `RSG_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_center_x) && $stable(o_center_y) && $stable(o_final_index))
    `RSG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid)
    `RSG_ASSERT(a_span_order, i_clk, i_rst_n, o_valid |-> o_first_index <= o_final_index)

endmodule

bind range_scan_gap_segmenter_unit rsg_checker u_rsg_checker (.*);
